// File: hw/rtl/line_pixel_rasterizer_macros.svh
// assertion macros used by the rasterizer checker
`ifndef LINE_PIXEL_RASTERIZER_MACROS_SVH
`define LINE_PIXEL_RASTERIZER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lpr_pkg.sv
// shared types, constants and helpers of the line pixel rasterizer
package lpr_pkg;

    localparam int LPR_SEGMENT_COUNT = 64;
    localparam int LPR_PAGE_COUNT    = 8;
    localparam int LPR_PAGE_ROWS     = 8;

    typedef enum logic [1:0] {
        LPR_IDLE,
        LPR_SETUP,
        LPR_DRAW
    } t_lpr_state;

    // stepping state of the line being drawn
    typedef struct packed {
        logic [5:0]        major_pos;
        logic [5:0]        minor_pos;
        logic [5:0]        major_stop;
        logic signed [7:0] step_error;
        logic [5:0]        major_delta;
        logic [5:0]        minor_delta;
        logic              minor_down;
    } t_lpr_walk;

    typedef struct packed {
        t_lpr_walk walk;
        logic      last;
    } t_lpr_step;

    // column modulo the segment count, segment count between 8 and 64
    function automatic logic [5:0] lpr_seg_of(input logic [5:0] x, input logic [6:0] segs);
        logic [6:0] v;
        v = {1'b0, x};
        for (int i = 0; i < 8; i++) begin
            if (v >= segs) begin
                v = v - segs;
            end
        end
        return v[5:0];
    endfunction

    function automatic logic [8:0] lpr_byte_index(input logic [5:0] x, input logic [5:0] y,
                                                  input logic [6:0] segs);
        logic [5:0] page;
        logic [9:0] prod;
        logic [9:0] sum;
        page = (y / 6'(LPR_PAGE_ROWS)) % 6'(LPR_PAGE_COUNT);
        prod = 10'(page[2:0]) * 10'(segs);
        sum  = prod + {4'b0000, lpr_seg_of(x, segs)};
        return sum[8:0];
    endfunction

endpackage

// File: hw/rtl/lpr_step_unit.sv
// one stepping update: error accumulate, minor step and end test
module lpr_step_unit (
    input  lpr_pkg::t_lpr_walk i_walk,
    output lpr_pkg::t_lpr_step o_step
);

    logic [5:0]        next_major;
    logic signed [7:0] err_sub;
    logic              minor_move;

    always_comb begin
        next_major = i_walk.major_pos + 6'd1;
        err_sub    = i_walk.step_error - $signed({2'b00, i_walk.minor_delta});
        minor_move = (err_sub <= 8'sd0);

        o_step.walk           = i_walk;
        o_step.walk.major_pos = next_major;
        if (minor_move) begin
            o_step.walk.step_error = err_sub + $signed({2'b00, i_walk.major_delta});
            if (i_walk.minor_down) begin
                o_step.walk.minor_pos = i_walk.minor_pos - 6'd1;
            end else begin
                o_step.walk.minor_pos = i_walk.minor_pos + 6'd1;
            end
        end else begin
            o_step.walk.step_error = err_sub;
        end
        // wrap to zero or reaching the far major coordinate ends the line
        o_step.last = (next_major == 6'd0) || (next_major >= i_walk.major_stop);
    end

endmodule

// File: hw/rtl/line_pixel_rasterizer.sv
// line pixel rasterizer top level: command intake, setup and pixel stepping
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall | x_start y_start x_end y_end pixel_on
//  out     | output    | o_out_valid/i_out_stall | pix_x pix_y byte_index bit_index set_bit
//          |           |                         | last_pixel
//
// a line of major delta d gives max(1, d) pixel beats; one stepping unit, one pixel a cycle unless stalled
// a command passes through intake, then setup, then pixel stepping while the output is free
// the input stalls from acceptance until the last pixel is loaded into the output register
// an output stall freezes the stepping unit; the last beat may wait while a new command enters
// reset is synchronous, clears the sequencer and the output valid
module line_pixel_rasterizer #(
    parameter int SEGMENT_COUNT = lpr_pkg::LPR_SEGMENT_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [5:0] i_x_start,
    input  logic [5:0] i_y_start,
    input  logic [5:0] i_x_end,
    input  logic [5:0] i_y_end,
    input  logic       i_pixel_on,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [5:0] o_pix_x,
    output logic [5:0] o_pix_y,
    output logic [8:0] o_byte_index,
    output logic [2:0] o_bit_index,
    output logic       o_set_bit,
    output logic       o_last_pixel
);

    lpr_pkg::t_lpr_state r_state, n_state;
    lpr_pkg::t_lpr_walk  r_walk, n_walk;
    lpr_pkg::t_lpr_step  step;

    logic [5:0] r_xa, n_xa, r_ya, n_ya, r_xb, n_xb, r_yb, n_yb;
    logic       r_on, n_on;
    logic       r_steep, n_steep;
    logic       r_out_valid, n_out_valid;
    logic [5:0] r_pix_x, n_pix_x, r_pix_y, n_pix_y;
    logic [8:0] r_byte_index, n_byte_index;
    logic [2:0] r_bit_index, n_bit_index;
    logic       r_set_bit, n_set_bit, r_last_pixel, n_last_pixel;

    logic       load;
    logic [5:0] dx, dy, ma, mi, mfar, mfar_minor;

    lpr_step_unit u_step (
        .i_walk (r_walk),
        .o_step (step)
    );

    always_comb begin
        n_state      = r_state;
        n_walk       = r_walk;
        n_xa         = r_xa;
        n_ya         = r_ya;
        n_xb         = r_xb;
        n_yb         = r_yb;
        n_on         = r_on;
        n_steep      = r_steep;
        n_pix_x      = r_pix_x;
        n_pix_y      = r_pix_y;
        n_byte_index = r_byte_index;
        n_bit_index  = r_bit_index;
        n_set_bit    = r_set_bit;
        n_last_pixel = r_last_pixel;
        load         = 1'b0;

        dx = (r_xa > r_xb) ? (r_xa - r_xb) : (r_xb - r_xa);
        dy = (r_ya > r_yb) ? (r_ya - r_yb) : (r_yb - r_ya);
        ma         = '0;
        mi         = '0;
        mfar       = '0;
        mfar_minor = '0;

        case (r_state)
            lpr_pkg::LPR_IDLE: begin
                if (i_in_valid) begin
                    n_xa    = i_x_start;
                    n_ya    = i_y_start;
                    n_xb    = i_x_end;
                    n_yb    = i_y_end;
                    n_on    = i_pixel_on;
                    n_state = lpr_pkg::LPR_SETUP;
                end
            end
            lpr_pkg::LPR_SETUP: begin
                n_steep = (dy > dx);
                // start from the endpoint with the smaller major coordinate
                if (dy > dx) begin
                    n_walk.major_delta = dy;
                    n_walk.minor_delta = dx;
                    if (r_ya <= r_yb) begin
                        ma = r_ya; mi = r_xa; mfar = r_yb; mfar_minor = r_xb;
                    end else begin
                        ma = r_yb; mi = r_xb; mfar = r_ya; mfar_minor = r_xa;
                    end
                end else begin
                    n_walk.major_delta = dx;
                    n_walk.minor_delta = dy;
                    if (r_xa <= r_xb) begin
                        ma = r_xa; mi = r_ya; mfar = r_xb; mfar_minor = r_yb;
                    end else begin
                        ma = r_xb; mi = r_yb; mfar = r_xa; mfar_minor = r_ya;
                    end
                end
                n_walk.major_pos  = ma;
                n_walk.minor_pos  = mi;
                n_walk.major_stop = mfar;
                n_walk.minor_down = (mfar_minor < mi);
                n_walk.step_error = $signed({2'b00, n_walk.major_delta});
                n_state           = lpr_pkg::LPR_DRAW;
            end
            lpr_pkg::LPR_DRAW: begin
                if (!r_out_valid || !i_out_stall) begin
                    load   = 1'b1;
                    n_walk = step.walk;
                    if (step.last) begin
                        n_state = lpr_pkg::LPR_IDLE;
                    end
                end
            end
            default: begin
                n_state = lpr_pkg::LPR_IDLE;
            end
        endcase

        if (load) begin
            n_pix_x      = r_steep ? r_walk.minor_pos : r_walk.major_pos;
            n_pix_y      = r_steep ? r_walk.major_pos : r_walk.minor_pos;
            n_byte_index = lpr_pkg::lpr_byte_index(n_pix_x, n_pix_y, 7'(SEGMENT_COUNT));
            n_bit_index  = n_pix_y[2:0];
            n_set_bit    = r_on;
            n_last_pixel = step.last;
            n_out_valid  = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpr_pkg::LPR_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk       <= n_walk;
        r_xa         <= n_xa;
        r_ya         <= n_ya;
        r_xb         <= n_xb;
        r_yb         <= n_yb;
        r_on         <= n_on;
        r_steep      <= n_steep;
        r_pix_x      <= n_pix_x;
        r_pix_y      <= n_pix_y;
        r_byte_index <= n_byte_index;
        r_bit_index  <= n_bit_index;
        r_set_bit    <= n_set_bit;
        r_last_pixel <= n_last_pixel;
    end

    assign o_in_stall   = (r_state != lpr_pkg::LPR_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_pix_x      = r_pix_x;
    assign o_pix_y      = r_pix_y;
    assign o_byte_index = r_byte_index;
    assign o_bit_index  = r_bit_index;
    assign o_set_bit    = r_set_bit;
    assign o_last_pixel = r_last_pixel;

endmodule

// File: hw/rtl/lpr_checker.sv
// port-level checks of the line pixel rasterizer, bound to the top level
`include "line_pixel_rasterizer_macros.svh"

module lpr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [5:0] o_pix_x,
    input logic [5:0] o_pix_y,
    input logic [8:0] o_byte_index,
    input logic [2:0] o_bit_index,
    input logic       o_set_bit,
    input logic       o_last_pixel
);

    logic out_beat;
    logic in_beat;

    assign out_beat = o_out_valid && !i_out_stall;
    assign in_beat  = i_in_valid && !o_in_stall;

    // a stalled beat holds
    `LPR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable({o_pix_x, o_pix_y, o_byte_index, o_bit_index,
                                o_set_bit, o_last_pixel}), "stalled pixel beat changed")

    // a pixel that is not the last means the line is still being drawn
    `LPR_ASSERT_NOW(a_busy_mid_line, i_clk, i_rst_n, o_out_valid && !o_last_pixel,
        o_in_stall, "new command accepted in the middle of a line")

    // after a non-last pixel is taken, the next one follows at once
    `LPR_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, out_beat && !o_last_pixel,
        o_out_valid && (o_pix_x != $past(o_pix_x) || o_pix_y != $past(o_pix_y)),
        "gap or repeated pixel inside a line")

    // a taken command occupies the block
    `LPR_ASSERT_NEXT(a_cmd_busy, i_clk, i_rst_n, in_beat, o_in_stall,
        "input not stalled after a command beat")

endmodule

bind line_pixel_rasterizer lpr_checker u_lpr_checker (.*);
